[rtl/spkseg_pkg.sv]
package spkseg_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned PROB_W     = 16;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned STREAM_W   = 21;
  localparam int unsigned OUT_TIME_W = 24;
  localparam int unsigned SPK_ID_W   = 2;
  localparam int unsigned FRAC_BITS  = 4;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = STREAM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ONSET_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_BEFORE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_AFTER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAM_FRAMES = 3'd6;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 16'd45875;

  // Parameter defaults
  localparam int unsigned DEF_SPEAKERS   = 4;
  localparam int unsigned DEF_FRAME_BITS = 20;

  typedef struct packed {
    logic [LEVEL_W-1:0]  onset_level;
    logic [LEVEL_W-1:0]  offset_level;
    logic [LEVEL_W-1:0]  pad_before;
    logic [LEVEL_W-1:0]  pad_after;
    logic [LEVEL_W-1:0]  min_gap;
    logic [LEVEL_W-1:0]  min_length;
    logic [STREAM_W-1:0] stream_frames;
  } cfg_t;

endpackage

[rtl/spkseg_lane.sv]
module spkseg_lane #(
  parameter int unsigned FRAME_BITS = spkseg_pkg::DEF_FRAME_BITS,
  parameter int unsigned TIME_W     = 25
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spkseg_pkg::cfg_t              cfg_i,
  input  logic                          accept_i,
  input  logic                          final_i,
  input  logic [spkseg_pkg::PROB_W-1:0] prob_i,
  input  logic [FRAME_BITS:0]           frame_index_i,
  input  logic                          advance_i,
  input  logic                          s1_final_i,
  output logic                          emit_a_o,
  output logic [TIME_W-1:0]             a_start_o,
  output logic [TIME_W-1:0]             a_end_o,
  output logic                          emit_b_o,
  output logic [TIME_W-1:0]             b_start_o,
  output logic [TIME_W-1:0]             b_end_o
);
  import spkseg_pkg::*;

  localparam int unsigned FI_W = FRAME_BITS + 1;

  // Hysteresis state
  logic            open_q, open_d;
  logic [FI_W-1:0] start_frame_q, start_frame_d;

  // First stage: the segment this frame produces, if any
  logic              seg_v_q, seg_v_d;
  logic [TIME_W-1:0] st_q, st_d;
  logic [TIME_W-1:0] en_q, en_d;

  // Pending segment awaiting merge
  logic              pv_q, pv_d;
  logic [TIME_W-1:0] ps_q, ps_d;
  logic [TIME_W-1:0] pe_q, pe_d;

  logic              open_evt, close_evt;
  logic [FI_W-1:0]   seg_frame;
  logic [TIME_W-1:0] seg_frame_t, now_t, total_t;
  logic [TIME_W:0]   end_sum;
  logic              merge, len_a_ok, len_b_ok;
  logic [TIME_W-1:0] merged_end;

  // Detect threshold crossings and form padded, clamped times
  always_comb begin
    open_evt    = !open_q && (prob_i > cfg_i.onset_level);
    close_evt   = open_q && (prob_i < cfg_i.offset_level);
    seg_frame   = open_evt ? frame_index_i : start_frame_q;
    seg_frame_t = TIME_W'({seg_frame, {FRAC_BITS{1'b0}}});
    now_t       = TIME_W'({frame_index_i, {FRAC_BITS{1'b0}}});
    total_t     = TIME_W'({cfg_i.stream_frames, {FRAC_BITS{1'b0}}});
    end_sum     = {1'b0, now_t} + (TIME_W+1)'(cfg_i.pad_after);

    st_d = (seg_frame_t < TIME_W'(cfg_i.pad_before)) ? '0
         : seg_frame_t - TIME_W'(cfg_i.pad_before);
    if (close_evt) begin
      en_d = (end_sum > {1'b0, total_t}) ? total_t : end_sum[TIME_W-1:0];
    end else begin
      en_d = total_t;
    end
    seg_v_d = close_evt || (final_i && (open_evt || open_q));

    open_d        = open_q;
    start_frame_d = start_frame_q;
    if (open_evt) begin
      open_d        = 1'b1;
      start_frame_d = frame_index_i;
    end else if (close_evt) begin
      open_d = 1'b0;
    end
    if (final_i) begin
      open_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q        <= 1'b0;
      start_frame_q <= '0;
      seg_v_q       <= 1'b0;
    end else if (accept_i) begin
      open_q        <= open_d;
      start_frame_q <= start_frame_d;
      seg_v_q       <= seg_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      st_q <= st_d;
      en_q <= en_d;
    end
  end

  // Merge into the pending segment, emit the older one, flush on the final frame
  always_comb begin
    merge      = pv_q && ({1'b0, st_q} < ({1'b0, pe_q} + (TIME_W+1)'(cfg_i.min_gap)));
    merged_end = (en_q > pe_q) ? en_q : pe_q;
    len_a_ok   = {1'b0, pe_q} >= ({1'b0, ps_q} + (TIME_W+1)'(cfg_i.min_length));

    pv_d     = pv_q;
    ps_d     = ps_q;
    pe_d     = pe_q;
    emit_a_o = 1'b0;
    if (seg_v_q) begin
      if (merge) begin
        pe_d = merged_end;
      end else begin
        emit_a_o = pv_q && len_a_ok;
        pv_d     = 1'b1;
        ps_d     = st_q;
        pe_d     = en_q;
      end
    end

    len_b_ok = {1'b0, pe_d} >= ({1'b0, ps_d} + (TIME_W+1)'(cfg_i.min_length));
    emit_b_o = s1_final_i && pv_d && len_b_ok;
    if (s1_final_i) begin
      pv_d = 1'b0;
    end

    a_start_o = ps_q;
    a_end_o   = pe_q;
    b_start_o = ps_d;
    b_end_o   = pe_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (advance_i) begin
      pv_q <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      ps_q <= ps_d;
      pe_q <= pe_d;
    end
  end

endmodule

[rtl/spkseg_merge.sv]
module spkseg_merge #(
  parameter int unsigned SPEAKERS = spkseg_pkg::DEF_SPEAKERS,
  parameter int unsigned TIME_W   = 25
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic [2*SPEAKERS-1:0]           emit_i,
  input  logic [TIME_W-1:0]               start_i [2*SPEAKERS],
  input  logic [TIME_W-1:0]               end_i   [2*SPEAKERS],
  output logic                            free_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [47:0]                     m_axis_tdata,  // seg_start, seg_end
  output logic [spkseg_pkg::SPK_ID_W-1:0] m_axis_tuser,  // speaker_id
  output logic                            m_axis_tlast   // last_of_run
);
  import spkseg_pkg::*;

  localparam int unsigned SLOTS  = 2 * SPEAKERS;
  localparam int unsigned SLOT_W = $clog2(SLOTS);

  logic [SLOTS-1:0]  mask_q, mask_d;
  logic [TIME_W-1:0] start_q [SLOTS];
  logic [TIME_W-1:0] end_q   [SLOTS];

  logic                  out_v_q, out_v_d;
  logic [OUT_TIME_W-1:0] out_start_q, out_end_q;
  logic [SPK_ID_W-1:0]   out_spk_q;
  logic                  out_last_q;

  logic [SLOT_W-1:0] sel;
  logic [SLOTS-1:0]  rest;
  logic              pop, last_pop;
  logic [TIME_W-1:0] sel_start, sel_end;

  // Pick the lowest pending slot: speakers ascending, older segment first
  always_comb begin
    sel = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = SLOT_W'(i);
      end
    end
    rest      = mask_q & ~(SLOTS'(1) << sel);
    pop       = (mask_q != '0) && (!out_v_q || m_axis_tready);
    last_pop  = pop && (rest == '0);
    free_o    = (mask_q == '0) || last_pop;
    sel_start = start_q[sel];
    sel_end   = end_q[sel];

    mask_d = mask_q;
    if (pop) begin
      mask_d = rest;
    end
    if (load_i) begin
      mask_d = emit_i;
    end

    out_v_d = out_v_q;
    if (m_axis_tready) begin
      out_v_d = 1'b0;
    end
    if (pop) begin
      out_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      mask_q  <= mask_d;
      out_v_q <= out_v_d;
    end
  end

  // Hold one frame's segments
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < SLOTS; i++) begin
        start_q[i] <= start_i[i];
        end_q[i]   <= end_i[i];
      end
    end
  end

  // Output register, times saturated to the output width
  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_start_q <= (sel_start[TIME_W-1:OUT_TIME_W] != '0) ? '1
                   : sel_start[OUT_TIME_W-1:0];
      out_end_q   <= (sel_end[TIME_W-1:OUT_TIME_W] != '0) ? '1
                   : sel_end[OUT_TIME_W-1:0];
      out_spk_q   <= SPK_ID_W'(sel >> 1);
      out_last_q  <= (rest == '0);
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_end_q, out_start_q};
  assign m_axis_tuser  = out_spk_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[rtl/speaker_activity_segmenter_core.sv]
// Speaker activity segmenter. Each input beat is one frame: SPEAKERS 16-bit
// probabilities in tdata (speaker 0 lowest) and tlast on the last frame of the
// stream. One lane per speaker applies onset/offset hysteresis, pads and clamps
// the segment times, and merges segments across short gaps; a merge stage then
// sends each finished segment as one output beat (start and end in 1/16 frame
// units, speaker in tuser, tlast on the last segment a frame caused). A frame
// is taken every cycle while earlier frames yield at most one segment and the
// output is not stalled; a frame that yields several segments (up to
// 2*SPEAKERS) sends them one by one through the single output register. Each
// beat passes the first stage, segment buffer and output register. Write the
// configuration registers only while the block is idle; tlast on an input beat
// returns all segment state to the start of a new stream.
module speaker_activity_segmenter_core #(
  parameter int unsigned SPEAKERS   = spkseg_pkg::DEF_SPEAKERS,
  parameter int unsigned FRAME_BITS = spkseg_pkg::DEF_FRAME_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration writes
  input  logic                              cfg_we_i,
  input  logic [spkseg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spkseg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Frames in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [SPEAKERS*16-1:0]            s_axis_tdata,  // prob_spk0, prob_spk1, ...
  input  logic                              s_axis_tlast,  // final_frame
  // Segments out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [47:0]                       m_axis_tdata,  // seg_start, seg_end
  output logic [spkseg_pkg::SPK_ID_W-1:0]   m_axis_tuser,  // speaker_id
  output logic                              m_axis_tlast   // last_of_run
);
  import spkseg_pkg::*;

  localparam int unsigned FI_W   = FRAME_BITS + 1;
  localparam int unsigned TIME_W = (FRAME_BITS + 5 > 25) ? FRAME_BITS + 5 : 25;
  localparam int unsigned SLOTS  = 2 * SPEAKERS;

  cfg_t cfg_q;

  logic            s1_valid_q, s1_final_q;
  logic [FI_W-1:0] frame_index_q;
  logic            accept, advance, buf_free;

  logic [SLOTS-1:0]  emit;
  logic [TIME_W-1:0] slot_start [SLOTS];
  logic [TIME_W-1:0] slot_end   [SLOTS];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.onset_level   <= LEVEL_RESET;
      cfg_q.offset_level  <= LEVEL_RESET;
      cfg_q.pad_before    <= '0;
      cfg_q.pad_after     <= '0;
      cfg_q.min_gap       <= '0;
      cfg_q.min_length    <= '0;
      cfg_q.stream_frames <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ONSET_LEVEL:   cfg_q.onset_level   <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_OFFSET_LEVEL:  cfg_q.offset_level  <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_PAD_BEFORE:    cfg_q.pad_before    <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_PAD_AFTER:     cfg_q.pad_after     <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_MIN_GAP:       cfg_q.min_gap       <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_MIN_LENGTH:    cfg_q.min_length    <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_STREAM_FRAMES: cfg_q.stream_frames <= cfg_wdata_i[STREAM_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: first stage drains into the segment buffer when it frees up
  assign advance       = s1_valid_q && buf_free;
  assign s_axis_tready = !s1_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s1_final_q    <= 1'b0;
      frame_index_q <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        s1_final_q <= s_axis_tlast;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      // Advance the frame counter, saturating; restart after the final frame
      if (accept) begin
        if (s_axis_tlast) begin
          frame_index_q <= '0;
        end else if (!frame_index_q[FRAME_BITS]) begin
          frame_index_q <= frame_index_q + FI_W'(1);
        end
      end
    end
  end

  for (genvar s = 0; s < SPEAKERS; s++) begin : g_lane
    spkseg_lane #(
      .FRAME_BITS (FRAME_BITS),
      .TIME_W     (TIME_W)
    ) u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cfg_i         (cfg_q),
      .accept_i      (accept),
      .final_i       (s_axis_tlast),
      .prob_i        (s_axis_tdata[s*PROB_W +: PROB_W]),
      .frame_index_i (frame_index_q),
      .advance_i     (advance),
      .s1_final_i    (s1_final_q),
      .emit_a_o      (emit[2*s]),
      .a_start_o     (slot_start[2*s]),
      .a_end_o       (slot_end[2*s]),
      .emit_b_o      (emit[2*s+1]),
      .b_start_o     (slot_start[2*s+1]),
      .b_end_o       (slot_end[2*s+1])
    );
  end

  spkseg_merge #(
    .SPEAKERS (SPEAKERS),
    .TIME_W   (TIME_W)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance),
    .emit_i        (emit),
    .start_i       (slot_start),
    .end_i         (slot_end),
    .free_o        (buf_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[dv/tb_speaker_activity_segmenter_core.sv]
module tb_speaker_activity_segmenter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import spkseg_pkg::*;

  localparam int unsigned N_SPK = DEF_SPEAKERS;
  localparam longint TIME_CAP = 16777215;
  localparam logic [STREAM_W-1:0] FRAME_SAT = STREAM_W'(1) << DEF_FRAME_BITS;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned MAX_REPORTS = 30;

  typedef struct {
    logic [SPK_ID_W-1:0]   spk;
    logic [OUT_TIME_W-1:0] seg_start;
    logic [OUT_TIME_W-1:0] seg_end;
    logic                  last;
  } seg_t;

  // Clock, reset and block inputs, all known from time zero
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [N_SPK*16-1:0] s_axis_tdata = '0;  // prob_spk0, prob_spk1, prob_spk2, prob_spk3
  logic s_axis_tlast = 1'b0;                // final_frame
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;                // seg_start, seg_end
  logic [SPK_ID_W-1:0] m_axis_tuser;        // speaker_id
  logic m_axis_tlast;                       // last_of_run

  // Segmenter mirror: settings and per-speaker stream state
  cfg_t settings;
  logic [STREAM_W-1:0] frame_idx;
  logic spk_open [N_SPK];
  logic [STREAM_W-1:0] open_frame [N_SPK];
  logic pend_valid [N_SPK];
  longint pend_start [N_SPK];
  longint pend_end [N_SPK];
  seg_t frame_segs [$];
  seg_t segs_due [$];

  int err_count = 0;
  int frames_sent = 0;
  bit idle_on = 1'b1;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;

  speaker_activity_segmenter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  function automatic cfg_t make_cfg(logic [LEVEL_W-1:0] onset, logic [LEVEL_W-1:0] offset,
                                    logic [LEVEL_W-1:0] pad_b, logic [LEVEL_W-1:0] pad_a,
                                    logic [LEVEL_W-1:0] gap, logic [LEVEL_W-1:0] min_len,
                                    logic [STREAM_W-1:0] frames);
    cfg_t c;
    c.onset_level   = onset;
    c.offset_level  = offset;
    c.pad_before    = pad_b;
    c.pad_after     = pad_a;
    c.min_gap       = gap;
    c.min_length    = min_len;
    c.stream_frames = frames;
    return c;
  endfunction

  // Return every speaker to the start of a new stream
  function automatic void clear_streams();
    frame_idx = '0;
    for (int s = 0; s < N_SPK; s++) begin
      spk_open[s]   = 1'b0;
      open_frame[s] = '0;
      pend_valid[s] = 1'b0;
      pend_start[s] = 0;
      pend_end[s]   = 0;
    end
  endfunction

  function automatic logic [OUT_TIME_W-1:0] clamp_time(longint t);
    if (t < 0) return '0;
    if (t > TIME_CAP) return '1;
    return t[OUT_TIME_W-1:0];
  endfunction

  // Emit the waiting segment of a speaker if it is long enough
  function automatic void flush_pending(int s);
    seg_t seg;
    if (pend_valid[s] && pend_end[s] - pend_start[s] >= longint'(settings.min_length)) begin
      seg.spk       = SPK_ID_W'(s);
      seg.seg_start = clamp_time(pend_start[s]);
      seg.seg_end   = clamp_time(pend_end[s]);
      seg.last      = 1'b0;
      frame_segs    = {frame_segs, seg};
    end
  endfunction

  // Merge a closed segment into the waiting one, or flush and replace it
  function automatic void add_segment(int s, longint st, longint en);
    if (pend_valid[s] && st - pend_end[s] < longint'(settings.min_gap)) begin
      if (en > pend_end[s]) pend_end[s] = en;
      return;
    end
    flush_pending(s);
    pend_valid[s] = 1'b1;
    pend_start[s] = st;
    pend_end[s]   = en;
  endfunction

  // Work out the segments that one accepted frame finishes
  function automatic void track_frame(logic [N_SPK*16-1:0] frame, logic is_final);
    logic [PROB_W-1:0] p;
    longint st, en, total, now;
    frame_segs.delete();
    total = longint'(settings.stream_frames) * 16;
    now   = longint'(frame_idx) * 16;
    for (int s = 0; s < N_SPK; s++) begin
      p = frame[16*s +: 16];
      if (!spk_open[s] && p > settings.onset_level) begin
        spk_open[s]   = 1'b1;
        open_frame[s] = frame_idx;
      end else if (spk_open[s] && p < settings.offset_level) begin
        st = longint'(open_frame[s]) * 16 - longint'(settings.pad_before);
        en = now + longint'(settings.pad_after);
        if (st < 0) st = 0;
        if (en > total) en = total;
        spk_open[s] = 1'b0;
        add_segment(s, st, en);
      end
      if (is_final) begin
        if (spk_open[s]) begin
          st = longint'(open_frame[s]) * 16 - longint'(settings.pad_before);
          if (st < 0) st = 0;
          spk_open[s] = 1'b0;
          add_segment(s, st, total);
        end
        flush_pending(s);
        pend_valid[s] = 1'b0;
      end
    end
    if (is_final) clear_streams();
    else if (frame_idx < FRAME_SAT) frame_idx++;
    if (frame_segs.size() > 0) frame_segs[frame_segs.size()-1].last = 1'b1;
    segs_due = {segs_due, frame_segs};
  endfunction

  // Predict on every accepted frame beat
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) track_frame(s_axis_tdata, s_axis_tlast);
  end

  // Compare each segment beat against the oldest prediction
  always @(posedge clk_i) begin
    seg_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (segs_due.size() == 0) begin
        if (err_count < MAX_REPORTS)
          $display("%0t: expected no segment, got spk %0d %0d..%0d last %0b", $time,
                   m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tlast);
        err_count++;
      end else begin
        want = segs_due.pop_front();
        if (want.spk !== m_axis_tuser || want.seg_start !== m_axis_tdata[23:0] ||
            want.seg_end !== m_axis_tdata[47:24] || want.last !== m_axis_tlast) begin
          if (err_count < MAX_REPORTS)
            $display("%0t: expected spk %0d %0d..%0d last %0b, got spk %0d %0d..%0d last %0b",
                     $time, want.spk, want.seg_start, want.seg_end, want.last, m_axis_tuser,
                     m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tlast);
          err_count++;
        end
      end
    end
  end

  // Stall the segment stream in random bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(99, 0) < stall_pct) begin
      stall_left    <= $urandom_range(15, 0);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one frame beat, after an optional gap, and hold it until taken
  task automatic send_frame(logic [15:0] p0, logic [15:0] p1, logic [15:0] p2,
                            logic [15:0] p3, logic is_final);
    if (idle_on && $urandom_range(99, 0) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p3, p2, p1, p0};
    s_axis_tlast  <= is_final;
    do @(posedge clk_i); while (!s_axis_tready);
    frames_sent++;
  endtask

  // Drop valid and let every predicted segment drain out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (segs_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all registers, one per cycle
  task automatic load_settings(cfg_t c);
    logic [CFG_IDX_W-1:0] idx_list [7];
    logic [CFG_DATA_W-1:0] val_list [7];
    idx_list = '{CFG_ONSET_LEVEL, CFG_OFFSET_LEVEL, CFG_PAD_BEFORE, CFG_PAD_AFTER,
                 CFG_MIN_GAP, CFG_MIN_LENGTH, CFG_STREAM_FRAMES};
    val_list = '{CFG_DATA_W'(c.onset_level), CFG_DATA_W'(c.offset_level),
                 CFG_DATA_W'(c.pad_before), CFG_DATA_W'(c.pad_after),
                 CFG_DATA_W'(c.min_gap), CFG_DATA_W'(c.min_length), c.stream_frames};
    for (int i = 0; i < 7; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx_list[i];
      cfg_wdata_i <= val_list[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings = c;
  endtask

  function automatic int pick_pct();
    case ($urandom_range(3, 0))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 50;
    endcase
  endfunction

  function automatic logic [15:0] pick_time();
    int r;
    r = $urandom_range(9, 0);
    if (r < 7) return 16'($urandom_range(48, 0));
    if (r < 9) return 16'($urandom_range(400, 0));
    return 16'($urandom);
  endfunction

  function automatic cfg_t random_settings(int len);
    cfg_t c;
    c.onset_level  = 16'($urandom_range(60000, 16000));
    c.offset_level = c.onset_level - 16'($urandom_range(15000, 0));
    if ($urandom_range(7, 0) == 0) begin
      c.onset_level  = 16'($urandom);
      c.offset_level = 16'($urandom);
    end
    c.pad_before = pick_time();
    c.pad_after  = pick_time();
    c.min_gap    = pick_time();
    c.min_length = pick_time();
    case ($urandom_range(5, 0))
      0: c.stream_frames = STREAM_W'($urandom);
      1: c.stream_frames = STREAM_W'($urandom_range(len, 0));
      default: c.stream_frames = STREAM_W'(len + $urandom_range(3, 0));
    endcase
    return c;
  endfunction

  // Probability that drives a speaker towards on or off, sometimes into the hold band
  function automatic logic [15:0] level_for(bit active);
    if ($urandom_range(99, 0) < 15 && settings.offset_level <= settings.onset_level)
      return 16'($urandom_range(settings.onset_level, settings.offset_level));
    if (active)
      return (settings.onset_level == '1) ? 16'hFFFF :
             16'($urandom_range(32'hFFFF, 32'(settings.onset_level) + 1));
    return (settings.offset_level == '0) ? 16'h0000 :
           16'($urandom_range(32'(settings.offset_level) - 1, 0));
  endfunction

  // One stream of random length: speaker activity with random content, or pure noise
  task automatic run_stream(int len, bit noisy);
    logic [15:0] probs [N_SPK];
    bit active [N_SPK];
    int flip_pct;
    flip_pct = $urandom_range(50, 5);
    foreach (active[s]) active[s] = 1'($urandom_range(1, 0));
    for (int f = 0; f < len; f++) begin
      for (int s = 0; s < N_SPK; s++) begin
        if ($urandom_range(99, 0) < flip_pct) active[s] = !active[s];
        probs[s] = noisy ? 16'($urandom) : level_for(active[s]);
      end
      send_frame(probs[0], probs[1], probs[2], probs[3], f == len - 1);
    end
  endtask

  task automatic play_streams(int target);
    int first, len;
    first = frames_sent;
    while (frames_sent - first < target) begin
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(3, 1) : $urandom_range(30, 4);
      wait_idle();
      gap_pct   = pick_pct();
      stall_pct = pick_pct();
      load_settings(random_settings(len));
      run_stream(len, $urandom_range(4, 0) == 0);
    end
  endtask

  // Reset settings: threshold edges, zero stream length
  task automatic test_reset_defaults();
    gap_pct   = 20;
    stall_pct = 20;
    send_frame(16'd45875, 16'd45876, 16'hFFFF, 16'h0000, 1'b0);
    send_frame(16'hFFFF, 16'd45874, 16'd45875, 16'h0000, 1'b0);
    send_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
  endtask

  // Register extremes: never close, never open, always merge and drop
  task automatic test_level_extremes();
    wait_idle();
    load_settings(make_cfg(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                           21'h1F_FFFF));
    send_frame(16'h0000, 16'h0001, 16'hFFFF, 16'h8000, 1'b0);
    send_frame(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_frame(16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF, 1'b1);
    wait_idle();
    load_settings(make_cfg(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
                           21'd100));
    send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    wait_idle();
    load_settings(make_cfg(16'h0000, 16'hFFFF, 16'd10, 16'hFFFF, 16'hFFFF, 16'hFFFF, 21'd8));
    send_frame(16'hFFFF, 16'h0001, 16'h0000, 16'hFFFF, 1'b0);
    send_frame(16'hFFFE, 16'hFFFF, 16'h0001, 16'h0000, 1'b0);
    send_frame(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b1);
  endtask

  // Every speaker flushes an old and a new segment on the final frame
  task automatic test_max_results();
    wait_idle();
    load_settings(make_cfg(16'd32768, 16'd16384, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                           21'd64));
    send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_frame(16'd20000, 16'd16384, 16'd32768, 16'd30000, 1'b0);
    send_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
  endtask

  // Padding clamps, gap merging, short drops and ends before starts
  task automatic test_merge_and_pad();
    wait_idle();
    load_settings(make_cfg(16'd40000, 16'd30000, 16'd40, 16'd24, 16'd20, 16'd60, 21'd6));
    send_frame(16'd50000, 16'd50000, 16'd50000, 16'd0, 1'b0);
    send_frame(16'd10000, 16'd50000, 16'd10000, 16'd0, 1'b0);
    send_frame(16'd50000, 16'd10000, 16'd0, 16'd0, 1'b0);
    send_frame(16'd10000, 16'd0, 16'd50000, 16'd0, 1'b0);
    send_frame(16'd0, 16'd0, 16'd50000, 16'd50000, 1'b0);
    send_frame(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_frame(16'd0, 16'd50000, 16'd0, 16'd0, 1'b1);
    wait_idle();
    load_settings(make_cfg(16'd40000, 16'd30000, 16'd0, 16'd0, 16'd0, 16'd0, 21'd0));
    send_frame(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_frame(16'd50000, 16'd50000, 16'd0, 16'd0, 1'b0);
    send_frame(16'd50000, 16'd0, 16'd0, 16'd0, 1'b1);
  endtask

  task automatic test_random_streams();
    idle_on = 1'b1;
    play_streams(300);
  endtask

  // Full-rate traffic on both sides
  task automatic test_steady_flow();
    wait_idle();
    idle_on = 1'b0;
    play_streams(45);
  endtask

  initial begin
    clear_streams();
    settings = make_cfg(LEVEL_RESET, LEVEL_RESET, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                        21'd0);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_level_extremes();
    test_max_results();
    test_merge_and_pad();
    test_random_streams();
    test_steady_flow();
    wait_idle();
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
